[src/pes_pkg.sv]
`default_nettype none

package pes_pkg;

  localparam int PERIOD_W  = 16;
  localparam int DUE_W     = 32;
  localparam int INDEX_W   = 4;
  localparam int COUNT_W   = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic                opcode;
    logic [INDEX_W-1:0]  entry_index;
    logic [PERIOD_W-1:0] period;
  } pes_in_t;

  typedef struct packed {
    logic [DUE_W-1:0]   due_time;
    logic [INDEX_W-1:0] chosen_index;
    logic               saturated;
  } pes_out_t;

  // Write strobes broadcast along the row of cells.
  typedef struct packed {
    logic due_we;
    logic per_we;
  } pes_wr_t;

endpackage

`default_nettype wire

[src/pes_cell.sv]
`default_nettype none

module pes_cell #(
  parameter int CELL_IDX   = 0,
  parameter int IDX_W      = 4,
  parameter int WI         = 4,
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          act,
  input  wire pes_pkg::pes_wr_t              wr,
  input  wire logic [WI-1:0]                 wr_idx,
  input  wire logic [TIME_WIDTH-1:0]         wr_due,
  input  wire logic [pes_pkg::PERIOD_W-1:0]  wr_per,
  input  wire logic                          tok_vld_in,
  input  wire logic                          tok_has_in,
  input  wire logic [TIME_WIDTH-1:0]         tok_due_in,
  input  wire logic [pes_pkg::PERIOD_W-1:0]  tok_per_in,
  input  wire logic [IDX_W-1:0]              tok_idx_in,
  output logic                               tok_vld_r,
  output logic                               tok_has_r,
  output logic [TIME_WIDTH-1:0]              tok_due_r,
  output logic [pes_pkg::PERIOD_W-1:0]       tok_per_r,
  output logic [IDX_W-1:0]                   tok_idx_r
);

  logic [pes_pkg::PERIOD_W-1:0] per_r;
  logic [TIME_WIDTH-1:0]        due_r;
  logic                         hit;
  logic                         take;

  assign hit  = (wr_idx == WI'(CELL_IDX));
  // Strict less-than keeps the earlier index on a tie, since the beat
  // travels from low to high index.
  assign take = tok_vld_in && act && (!tok_has_in || (due_r < tok_due_in));

  always_ff @(posedge clk) begin
    if (wr.due_we && hit) begin
      due_r <= wr_due;
    end
    if (wr.per_we && hit) begin
      per_r <= wr_per;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_has_r <= tok_has_in || take;
    if (take) begin
      tok_due_r <= due_r;
      tok_per_r <= per_r;
      tok_idx_r <= IDX_W'(CELL_IDX);
    end else begin
      tok_due_r <= tok_due_in;
      tok_per_r <= tok_per_in;
      tok_idx_r <= tok_idx_in;
    end
  end

endmodule

`default_nettype wire

[src/periodic_event_scheduler.sv]
// Load beats write one entry and produce no result.
// A step beat walks the row of cells, one cell per cycle, into the finish
// stage, and is retired into the output register once the output can take it;
// the block takes no new beat until that step has retired.
// Reset is synchronous, active low: it clears handshake state and sets
// active_count to 16. Period and due values are undefined until loaded.
`default_nettype none

module periodic_event_scheduler #(
  parameter int MAX_ENTRIES = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire pes_pkg::pes_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pes_pkg::pes_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [pes_pkg::COUNT_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int WI    = (IDX_W > pes_pkg::INDEX_W) ? IDX_W : pes_pkg::INDEX_W;

  logic [pes_pkg::COUNT_W-1:0]  cnt_r;
  logic                         busy_r;
  logic                         out_valid_r;
  pes_pkg::pes_out_t            out_data_r;

  logic                         fin_valid_r;
  logic [TIME_WIDTH-1:0]        fin_due_r;
  logic [pes_pkg::PERIOD_W-1:0] fin_per_r;
  logic [IDX_W-1:0]             fin_idx_r;

  logic                         in_acc;
  logic                         ld;
  logic                         start;
  logic                         retire;
  logic [TIME_WIDTH:0]          sum;
  logic                         sat;
  logic [TIME_WIDTH-1:0]        next_due;

  pes_pkg::pes_wr_t             wr;
  logic [WI-1:0]                wr_idx;
  logic [TIME_WIDTH-1:0]        wr_due;

  logic                         tok_vld [MAX_ENTRIES];
  logic                         tok_has [MAX_ENTRIES];
  logic [TIME_WIDTH-1:0]        tok_due [MAX_ENTRIES];
  logic [pes_pkg::PERIOD_W-1:0] tok_per [MAX_ENTRIES];
  logic [IDX_W-1:0]             tok_idx [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]       tok_vld_vec;

  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_acc = in_valid && in_ready;
  assign ld     = in_acc && (in_data.opcode == pes_pkg::OP_LOAD);
  // With no active entries a step is consumed without a result.
  assign start  = in_acc && (in_data.opcode == pes_pkg::OP_STEP) && (cnt_r != '0);
  assign retire = fin_valid_r && (!out_valid_r || out_ready);

  assign sum      = {1'b0, fin_due_r} + (TIME_WIDTH+1)'(fin_per_r);
  assign sat      = sum[TIME_WIDTH];
  assign next_due = sat ? '1 : sum[TIME_WIDTH-1:0];

  always_comb begin
    wr.due_we = ld || retire;
    wr.per_we = ld;
    if (ld) begin
      wr_idx = WI'(in_data.entry_index);
      wr_due = TIME_WIDTH'(in_data.period);
    end else begin
      wr_idx = WI'(fin_idx_r);
      wr_due = next_due;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic                         vld_in;
      logic                         has_in;
      logic [TIME_WIDTH-1:0]        due_in;
      logic [pes_pkg::PERIOD_W-1:0] per_in;
      logic [IDX_W-1:0]             idx_in;
      logic                         act;

      if (gi == 0) begin : g_head
        assign vld_in = start;
        assign has_in = 1'b0;
        assign due_in = '0;
        assign per_in = '0;
        assign idx_in = '0;
      end else begin : g_link
        assign vld_in = tok_vld[gi-1];
        assign has_in = tok_has[gi-1];
        assign due_in = tok_due[gi-1];
        assign per_in = tok_per[gi-1];
        assign idx_in = tok_idx[gi-1];
      end

      // Counts above the row length cover every cell.
      assign act = (32'(cnt_r) > 32'(gi));
      assign tok_vld_vec[gi] = tok_vld[gi];

      pes_cell #(
        .CELL_IDX   (gi),
        .IDX_W      (IDX_W),
        .WI         (WI),
        .TIME_WIDTH (TIME_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .act        (act),
        .wr         (wr),
        .wr_idx     (wr_idx),
        .wr_due     (wr_due),
        .wr_per     (in_data.period),
        .tok_vld_in (vld_in),
        .tok_has_in (has_in),
        .tok_due_in (due_in),
        .tok_per_in (per_in),
        .tok_idx_in (idx_in),
        .tok_vld_r  (tok_vld[gi]),
        .tok_has_r  (tok_has[gi]),
        .tok_due_r  (tok_due[gi]),
        .tok_per_r  (tok_per[gi]),
        .tok_idx_r  (tok_idx[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= pes_pkg::COUNT_RESET;
      busy_r      <= 1'b0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cnt_r <= cfg_wdata;
      end
      if (start) begin
        busy_r <= 1'b1;
      end else if (retire) begin
        busy_r <= 1'b0;
      end
      if (tok_vld[MAX_ENTRIES-1]) begin
        fin_valid_r <= 1'b1;
      end else if (retire) begin
        fin_valid_r <= 1'b0;
      end
      if (retire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld[MAX_ENTRIES-1]) begin
      fin_due_r <= tok_due[MAX_ENTRIES-1];
      fin_per_r <= tok_per[MAX_ENTRIES-1];
      fin_idx_r <= tok_idx[MAX_ENTRIES-1];
    end
    if (retire) begin
      out_data_r.due_time     <= pes_pkg::DUE_W'(fin_due_r);
      out_data_r.chosen_index <= pes_pkg::INDEX_W'(fin_idx_r);
      out_data_r.saturated    <= sat;
    end
  end

  // Only one step is ever in flight along the row or in the finish stage.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_vld_vec, fin_valid_r}))
    else $error("more than one step beat in flight");

  // A beat leaving the last cell always carries a chosen entry.
  a_tail_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    tok_vld[MAX_ENTRIES-1] |-> tok_has[MAX_ENTRIES-1])
    else $error("step reached the end of the row without a candidate");

  // The finish stage only holds a step while the input side is blocked.
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid_r |-> busy_r)
    else $error("finish stage valid while not busy");

  // A step that is started leaves the block busy until it retires.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && !in_ready))
    else $error("step accepted but block not busy");

endmodule

`default_nettype wire

[tb/tb_periodic_event_scheduler.sv]
`timescale 1ns / 100ps

module tb_periodic_event_scheduler;

  localparam int ENTRIES        = 16;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_BEATS   = 1750;
  localparam int WATCHDOG_LIMIT = 2000;

  // Tracks period and due time of every entry and queues the events that
  // each step beat should fire.
  class schedule_ledger;
    logic [pes_pkg::PERIOD_W-1:0] period_tbl [ENTRIES];
    logic [pes_pkg::DUE_W-1:0]    due_tbl [ENTRIES];
    logic [pes_pkg::COUNT_W-1:0]  active_cnt;
    pes_pkg::pes_out_t            upcoming [$];
    int unsigned                  failures;

    function new();
      active_cnt = pes_pkg::COUNT_RESET;
      failures = 0;
      foreach (period_tbl[i]) begin
        period_tbl[i] = '0;
        due_tbl[i] = '0;
      end
    endfunction

    function void set_count(logic [pes_pkg::COUNT_W-1:0] value);
      active_cnt = value;
    endfunction

    function int unsigned pending();
      return upcoming.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function void note_beat(pes_pkg::pes_in_t beat);
      int unsigned                 live;
      int unsigned                 best;
      int unsigned                 i;
      logic [pes_pkg::DUE_W:0]     advanced;
      pes_pkg::pes_out_t           ev;
      if (beat.opcode == pes_pkg::OP_LOAD) begin
        period_tbl[beat.entry_index] = beat.period;
        due_tbl[beat.entry_index] = pes_pkg::DUE_W'(beat.period);
        return;
      end
      live = (active_cnt > ENTRIES) ? ENTRIES : active_cnt;
      // With no active entries a step is consumed without firing anything.
      if (live == 0) begin
        return;
      end
      best = 0;
      for (i = 1; i < live; i++) begin
        if (due_tbl[i] < due_tbl[best]) begin
          best = i;
        end
      end
      ev.due_time = due_tbl[best];
      ev.chosen_index = pes_pkg::INDEX_W'(best);
      // A carry out of the time width means the advance clips at the top.
      advanced = {1'b0, due_tbl[best]} + (pes_pkg::DUE_W + 1)'(period_tbl[best]);
      ev.saturated = advanced[pes_pkg::DUE_W];
      due_tbl[best] = advanced[pes_pkg::DUE_W] ? '1 : advanced[pes_pkg::DUE_W-1:0];
      upcoming.push_back(ev);
    endfunction

    function void check_result(pes_pkg::pes_out_t got);
      pes_pkg::pes_out_t exp;
      if (upcoming.size() == 0) begin
        flag($sformatf("event with nothing expected: due=%0d idx=%0d sat=%0b",
                       got.due_time, got.chosen_index, got.saturated));
        return;
      end
      exp = upcoming.pop_front();
      if (got.due_time !== exp.due_time || got.chosen_index !== exp.chosen_index ||
          got.saturated !== exp.saturated) begin
        flag($sformatf({"event mismatch: expected due=%0d idx=%0d sat=%0b, ",
                        "got due=%0d idx=%0d sat=%0b"},
                       exp.due_time, exp.chosen_index, exp.saturated,
                       got.due_time, got.chosen_index, got.saturated));
      end
    endfunction

    function void close();
      if (upcoming.size() != 0) begin
        flag($sformatf("%0d expected events never arrived", upcoming.size()));
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  pes_pkg::pes_in_t            in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  pes_pkg::pes_out_t           out_data;
  logic                        cfg_we = 1'b0;
  logic [pes_pkg::COUNT_W-1:0] cfg_wdata = '0;

  schedule_ledger     ledger;
  logic               calm = 1'b0;
  logic [ENTRIES-1:0] loaded = '0;
  int unsigned        beats_sent = 0;
  int unsigned        hold = 0;
  int unsigned        quiet = 0;

  periodic_event_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Small periods are favored so that due times collide and ties occur.
  function automatic logic [pes_pkg::PERIOD_W-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end else if (r < 10) begin
      return pes_pkg::PERIOD_W'($urandom_range(1, 20));
    end
    return pes_pkg::PERIOD_W'($urandom);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold <= 0;
    end else if (hold != 0) begin
      out_ready <= 1'b0;
      hold <= hold - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      hold <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      ledger.note_beat(in_data);
    end
    if (rst_n && out_valid && out_ready) begin
      ledger.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_beat(input pes_pkg::pes_in_t beat);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic load_entry(input int unsigned idx,
                            input logic [pes_pkg::PERIOD_W-1:0] per);
    pes_pkg::pes_in_t beat;
    beat.opcode = pes_pkg::OP_LOAD;
    beat.entry_index = pes_pkg::INDEX_W'(idx);
    beat.period = per;
    loaded[idx] = 1'b1;
    send_beat(beat);
  endtask

  // Index and period are don't-care on a step, so they carry random bits.
  task automatic fire_step();
    pes_pkg::pes_in_t beat;
    beat.opcode = pes_pkg::OP_STEP;
    beat.entry_index = pes_pkg::INDEX_W'($urandom);
    beat.period = pes_pkg::PERIOD_W'($urandom);
    send_beat(beat);
  endtask

  // Holds off the sender until every pending event is out and the block
  // has had time to finish a step that fires nothing.
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active(input logic [pes_pkg::COUNT_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_count(value);
  endtask

  initial begin
    int unsigned                 r;
    int unsigned                 live;
    int unsigned                 phase_len;
    int unsigned                 start_beats;
    logic [pes_pkg::COUNT_W-1:0] cnt;
    ledger = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Period zero pins its entry, all-ones period at the other extreme.
    set_active(5'd2);
    load_entry(0, 16'h0000);
    load_entry(1, 16'hFFFF);
    fire_step();
    fire_step();
    // Equal due times go to the lower index.
    load_entry(0, 16'd7);
    load_entry(1, 16'd7);
    fire_step();
    fire_step();
    fire_step();
    load_entry(15, 16'd1);
    // No active entries: steps are taken but fire nothing.
    set_active(5'd0);
    fire_step();
    fire_step();

    // One entry with the largest period steps back to back with the
    // output side always ready.
    calm <= 1'b1;
    set_active(5'd1);
    load_entry(0, 16'hFFFF);
    repeat (40) fire_step();
    calm <= 1'b0;

    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        cnt = 5'd0;
      end else if (r == 1) begin
        cnt = 5'd1;
      end else if (r == 2) begin
        cnt = 5'd16;
      end else if (r == 3) begin
        cnt = pes_pkg::COUNT_W'($urandom_range(17, 31));
      end else begin
        cnt = pes_pkg::COUNT_W'($urandom_range(2, 16));
      end
      set_active(cnt);
      calm <= ($urandom_range(0, 4) == 0);
      live = (cnt > ENTRIES) ? ENTRIES : cnt;
      for (int i = 0; i < live; i++) begin
        if (!loaded[i]) begin
          load_entry(i, pick_period());
        end
      end
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < 70) begin
          fire_step();
        end else begin
          load_entry($urandom_range(0, ENTRIES - 1), pick_period());
        end
        if ($urandom_range(0, 199) == 0) begin
          drain();
        end
      end
    end

    drain();
    ledger.close();
    if (ledger.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
